>>> src/ptv_pkg.sv
// ----------------------------------------------------------------------------
// Pose tracker package
// Shared widths, register indexes, reset values and the octant sine/cosine
// series that builds the lookup table of the pose tracker.
// ----------------------------------------------------------------------------
package ptv_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int POS_BITS_DEF   = 16;

  localparam int MOVE_W    = 8;
  localparam int TURN_W    = 10;
  localparam int HFOV_W    = 12;
  localparam int CFG_IDX_W = 3;
  // Q30 sine and cosine of an angle in the first octant fit in 31 bits.
  localparam int SC_W      = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE_HALF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd4;

  localparam logic [MOVE_W-1:0] MOVE_STEP_RST = 8'd16;
  localparam logic [TURN_W-1:0] TURN_STEP_RST = 10'd64;
  localparam logic [HFOV_W-1:0] CONE_HALF_RST = 12'd398;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Restoring division, used only while the lookup table is built.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine and cosine in Q30 of a folded angle f given in 2^-20 turn units,
  // f in 0..2^17. Five truncating Taylor correction terms each.
  function automatic logic [2*SC_W-1:0] sincos_oct(input logic [17:0] f);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint          sin_sum;
    longint          cos_sum;
    x       = (64'(f) * PI_Q30 + 64'd262144) >> 19;
    x2      = (x * x) >> 30;
    term    = x;
    sin_sum = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      den  = 64'((2 * k) * (2 * k + 1));
      term = udiv64((term * x2) >> 30, den);
      if ((k & 1) == 1) sin_sum = sin_sum - longint'(term);
      else              sin_sum = sin_sum + longint'(term);
    end
    term    = 64'd1 << 30;
    cos_sum = longint'(term);
    for (int k = 1; k <= 5; k++) begin
      den  = 64'((2 * k - 1) * (2 * k));
      term = udiv64((term * x2) >> 30, den);
      if ((k & 1) == 1) cos_sum = cos_sum - longint'(term);
      else              cos_sum = cos_sum + longint'(term);
    end
    return {sin_sum[SC_W-1:0], cos_sum[SC_W-1:0]};
  endfunction

endpackage

>>> src/ptv_if.sv
// ----------------------------------------------------------------------------
// Pose tracker channels
// Valid/ready channels for requests into and results out of the tracker.
// ----------------------------------------------------------------------------
interface ptv_in_if #(
  parameter int POS_BITS = ptv_pkg::POS_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                func;
  logic                key_forward;
  logic                key_backward;
  logic                key_left;
  logic                key_right;
  logic [POS_BITS-1:0] obj_x;
  logic [POS_BITS-1:0] obj_y;

  modport source (
    output valid, func, key_forward, key_backward, key_left, key_right, obj_x, obj_y,
    input  ready
  );
  modport sink (
    input  valid, func, key_forward, key_backward, key_left, key_right, obj_x, obj_y,
    output ready
  );
endinterface

interface ptv_out_if #(
  parameter int POS_BITS   = ptv_pkg::POS_BITS_DEF,
  parameter int ANGLE_BITS = ptv_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  visible;
  logic [POS_BITS-1:0]   pos_x;
  logic [POS_BITS-1:0]   pos_y;
  logic [ANGLE_BITS-1:0] heading;

  modport source (
    output valid, visible, pos_x, pos_y, heading,
    input  ready
  );
  modport sink (
    input  valid, visible, pos_x, pos_y, heading,
    output ready
  );
endinterface

>>> src/pose_tracker_with_view_cone_test_top.sv
// ----------------------------------------------------------------------------
// Pose tracker with view-cone test
// Keeps a 2-D player pose and answers visibility requests for object points.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_i (valid/ready) and every request produces one
// result on out_o. A request with func low is a movement tick: forward, then
// backward steps of move_step along the heading, then left and right turns.
// A request with func high tests whether obj_x/obj_y lies strictly within
// the cone half-width of the heading. Results carry the pose as it stands
// afterwards. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle; any valid write reloads the position from
// start_x/start_y.
// Timing: sine and cosine come from a registered table; products are formed
// bit-serially by a shift-add unit, one multiplier bit per cycle. A tick
// passes through ST_RD, ST_MUL, ST_T_FWD, ST_T_BWD, ST_T_TURN and ST_OUT. A
// request runs a binary search of up to ANGLE_BITS - 2 rounds, each through
// ST_Q_ROM, ST_RD, ST_MUL and ST_Q_CMP, then ST_Q_DIR and ST_OUT. Ready
// rises together with the result.
// Only one request is in flight, but a new one is accepted while the last
// result still waits on out_o; a stalled receiver holds the next result in
// the finishing state. Reset loads the register defaults, position zero and
// heading zero; the sine table is constant and needs no clearing pass.
// ----------------------------------------------------------------------------
module pose_tracker_with_view_cone_test_top #(
  parameter int ANGLE_BITS = ptv_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = ptv_pkg::POS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ptv_in_if.sink                        in_i,
  ptv_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [ptv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [POS_BITS-1:0]           cfg_data_i
);
  import ptv_pkg::*;

  localparam int AB     = ANGLE_BITS;
  localparam int PB     = POS_BITS;
  localparam int ROM_N  = (1 << (AB - 2)) + 1;
  localparam int IDX_W  = AB - 1;
  localparam int OCT_W  = AB - 2;
  localparam int AW     = PB + SC_W;
  localparam int CNT_W  = $clog2(PB + 1);
  localparam int RND_W  = MOVE_W + 1;
  localparam int HW     = (AB > TURN_W) ? AB : TURN_W;
  localparam int CMP_W  = (AB > HFOV_W) ? AB : HFOV_W;

  localparam logic [OCT_W-1:0] OCT_HALF = OCT_W'(1) << (AB - 3);
  localparam logic [AB-1:0]    QUARTER  = AB'(1) << (AB - 2);
  localparam logic [AB-1:0]    HALF     = AB'(1) << (AB - 1);
  localparam logic [AW-1:0]    RND_HALF = AW'(1) << 29;

  typedef logic [2*SC_W-1:0] rom_t [ROM_N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_N; i++) begin
      r[i] = sincos_oct(18'(i << (19 - AB)));
    end
    return r;
  endfunction

  localparam rom_t SC_ROM = build_rom();

  function automatic logic [PB-1:0] step_pos(input logic [PB-1:0]    p,
                                             input logic [RND_W-1:0] m,
                                             input logic             neg);
    logic [PB:0]   s;
    logic [PB-1:0] res;
    if (neg) begin
      s   = {1'b0, p} - (PB+1)'(m);
      res = s[PB] ? '0 : s[PB-1:0];
    end else begin
      s   = {1'b0, p} + (PB+1)'(m);
      res = s[PB] ? '1 : s[PB-1:0];
    end
    return res;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_T_FWD, ST_T_BWD, ST_T_TURN,
    ST_Q_ROM, ST_Q_CMP, ST_Q_DIR, ST_OUT
  } state_e;

  state_e              state_q;
  logic [MOVE_W-1:0]   move_step_q;
  logic [TURN_W-1:0]   turn_step_q;
  logic [HFOV_W-1:0]   cone_half_q;
  logic [PB-1:0]       start_x_q, start_y_q;
  logic [PB-1:0]       px_q, py_q;
  logic [AB-1:0]       heading_q;

  logic                func_q;
  logic [3:0]          keys_q;     // forward, backward, left, right
  logic [IDX_W-1:0]    addr_q;
  logic [2*SC_W-1:0]   rom_dat_q;
  logic [1:0]          quad_q;
  logic                fswap_q;
  logic [PB-1:0]       big_q, small_q;
  logic                sx_q, sy_q, oswap_q, zero_q;
  logic [OCT_W-1:0]    lo_q, hi_q, mid_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [PB-1:0]       m1_q, m2_q;
  logic [AW-1:0]       acc1_q, acc2_q;
  logic                vis_q;

  logic                out_valid_q;
  logic                out_vis_q;
  logic [PB-1:0]       out_px_q, out_py_q;
  logic [AB-1:0]       out_head_q;

  // Sine/cosine table, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    rom_dat_q <= SC_ROM[addr_q];
  end

  // Unfold the table entry into cosine and sine magnitudes.
  logic [SC_W-1:0] fs, fc, ss, cc, mag_c, mag_s;
  logic            neg_c, neg_s;
  always_comb begin
    fs    = rom_dat_q[2*SC_W-1:SC_W];
    fc    = rom_dat_q[SC_W-1:0];
    ss    = fswap_q ? fc : fs;
    cc    = fswap_q ? fs : fc;
    mag_c = quad_q[0] ? ss : cc;
    mag_s = quad_q[0] ? cc : ss;
    neg_c = (quad_q == 2'd1) || (quad_q == 2'd2);
    neg_s = quad_q[1];
  end

  logic [AW-1:0]    rnd_x, rnd_y;
  logic [RND_W-1:0] step_x, step_y;
  assign rnd_x  = acc1_q + RND_HALF;
  assign rnd_y  = acc2_q + RND_HALF;
  assign step_x = rnd_x[30 +: RND_W];
  assign step_y = rnd_y[30 +: RND_W];

  // Heading folded into the first octant for the table address.
  logic [OCT_W-1:0] h_low, h_fold;
  logic             h_swap;
  always_comb begin
    h_low  = heading_q[OCT_W-1:0];
    h_swap = h_low > OCT_HALF;
    h_fold = h_swap ? (OCT_W'(0) - h_low) : h_low;
  end

  // Direction of the request vector relative to the player.
  logic [PB:0]   dx_s, dy_s;
  logic [PB-1:0] ax, ay;
  always_comb begin
    dx_s = {1'b0, in_i.obj_x} - {1'b0, px_q};
    dy_s = {1'b0, in_i.obj_y} - {1'b0, py_q};
    ax   = dx_s[PB] ? PB'(-dx_s) : dx_s[PB-1:0];
    ay   = dy_s[PB] ? PB'(-dy_s) : dy_s[PB-1:0];
  end

  logic [AB-1:0]    t_ang, dir_ang, d_ang, mag_ang;
  logic             vis_c;
  logic [OCT_W:0]   mid_sum;
  logic [HW-1:0]    turn_sum;
  always_comb begin
    t_ang = oswap_q ? (QUARTER - AB'(lo_q)) : AB'(lo_q);
    if (zero_q)             dir_ang = '0;
    else if (!sx_q && !sy_q) dir_ang = t_ang;
    else if (sx_q && !sy_q)  dir_ang = HALF - t_ang;
    else if (sx_q)           dir_ang = HALF + t_ang;
    else                     dir_ang = AB'(0) - t_ang;
    d_ang   = dir_ang - heading_q;
    mag_ang = d_ang[AB-1] ? (AB'(0) - d_ang) : d_ang;
    vis_c   = CMP_W'(mag_ang) < CMP_W'(cone_half_q);
    mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
    turn_sum = HW'(heading_q) - (keys_q[1] ? HW'(turn_step_q) : HW'(0))
             + (keys_q[0] ? HW'(turn_step_q) : HW'(0));
  end

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.visible = out_vis_q;
  assign out_o.pos_x   = out_px_q;
  assign out_o.pos_y   = out_py_q;
  assign out_o.heading = out_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      move_step_q <= MOVE_STEP_RST;
      turn_step_q <= TURN_STEP_RST;
      cone_half_q <= CONE_HALF_RST;
      start_x_q   <= '0;
      start_y_q   <= '0;
      px_q        <= '0;
      py_q        <= '0;
      heading_q   <= '0;
      func_q      <= 1'b0;
      keys_q      <= '0;
      addr_q      <= '0;
      quad_q      <= '0;
      fswap_q     <= 1'b0;
      big_q       <= '0;
      small_q     <= '0;
      sx_q        <= 1'b0;
      sy_q        <= 1'b0;
      oswap_q     <= 1'b0;
      zero_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      cnt_q       <= '0;
      m1_q        <= '0;
      m2_q        <= '0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      vis_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_vis_q   <= 1'b0;
      out_px_q    <= '0;
      out_py_q    <= '0;
      out_head_q  <= '0;
    end else begin
      if (out_o.ready && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            func_q <= in_i.func;
            keys_q <= {in_i.key_forward, in_i.key_backward, in_i.key_left, in_i.key_right};
            vis_q  <= 1'b0;
            if (!in_i.func) begin
              quad_q  <= heading_q[AB-1:AB-2];
              fswap_q <= h_swap;
              addr_q  <= {h_fold, 1'b0};
              state_q <= ST_RD;
            end else begin
              quad_q  <= '0;
              fswap_q <= 1'b0;
              sx_q    <= dx_s[PB];
              sy_q    <= dy_s[PB];
              zero_q  <= (ax == '0) && (ay == '0);
              oswap_q <= ay > ax;
              big_q   <= (ay > ax) ? ay : ax;
              small_q <= (ay > ax) ? ax : ay;
              lo_q    <= '0;
              hi_q    <= OCT_HALF;
              state_q <= ST_Q_ROM;
            end
          end
        end

        ST_Q_ROM: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_sum[OCT_W-1:0];
            addr_q  <= {mid_sum[OCT_W-1:0], 1'b1};
            state_q <= ST_RD;
          end else begin
            state_q <= ST_Q_DIR;
          end
        end

        ST_RD: begin
          acc1_q <= '0;
          acc2_q <= '0;
          if (!func_q) begin
            m1_q  <= {move_step_q, {(PB-MOVE_W){1'b0}}};
            m2_q  <= {move_step_q, {(PB-MOVE_W){1'b0}}};
            cnt_q <= CNT_W'(MOVE_W - 1);
          end else begin
            m1_q  <= small_q;
            m2_q  <= big_q;
            cnt_q <= CNT_W'(PB - 1);
          end
          state_q <= ST_MUL;
        end

        // MSB-first shift-add, one multiplier bit per cycle.
        ST_MUL: begin
          acc1_q <= (acc1_q << 1) + (m1_q[PB-1] ? AW'(mag_c) : AW'(0));
          acc2_q <= (acc2_q << 1) + (m2_q[PB-1] ? AW'(mag_s) : AW'(0));
          m1_q   <= m1_q << 1;
          m2_q   <= m2_q << 1;
          cnt_q  <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) state_q <= func_q ? ST_Q_CMP : ST_T_FWD;
        end

        ST_T_FWD: begin
          if (keys_q[3]) begin
            px_q <= step_pos(px_q, step_x, neg_c);
            py_q <= step_pos(py_q, step_y, neg_s);
          end
          state_q <= ST_T_BWD;
        end

        ST_T_BWD: begin
          if (keys_q[2]) begin
            px_q <= step_pos(px_q, step_x, !neg_c);
            py_q <= step_pos(py_q, step_y, !neg_s);
          end
          state_q <= ST_T_TURN;
        end

        ST_T_TURN: begin
          heading_q <= turn_sum[AB-1:0];
          state_q   <= ST_OUT;
        end

        // The boundary lies below the vector when small*cos >= big*sin.
        ST_Q_CMP: begin
          if (acc1_q >= acc2_q) lo_q <= mid_q + OCT_W'(1);
          else                  hi_q <= mid_q;
          state_q <= ST_Q_ROM;
        end

        ST_Q_DIR: begin
          vis_q   <= vis_c;
          state_q <= ST_OUT;
        end

        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_vis_q   <= vis_q;
            out_px_q    <= px_q;
            out_py_q    <= py_q;
            out_head_q  <= heading_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOVE_STEP: begin
            move_step_q <= cfg_data_i[MOVE_W-1:0];
            px_q        <= start_x_q;
            py_q        <= start_y_q;
          end
          CFG_TURN_STEP: begin
            turn_step_q <= cfg_data_i[TURN_W-1:0];
            px_q        <= start_x_q;
            py_q        <= start_y_q;
          end
          CFG_CONE_HALF: begin
            cone_half_q <= cfg_data_i[HFOV_W-1:0];
            px_q        <= start_x_q;
            py_q        <= start_y_q;
          end
          CFG_START_X: begin
            start_x_q <= cfg_data_i;
            px_q      <= cfg_data_i;
            py_q      <= start_y_q;
          end
          CFG_START_Y: begin
            start_y_q <= cfg_data_i;
            px_q      <= start_x_q;
            py_q      <= cfg_data_i;
          end
          default: ;
        endcase
      end
    end
  end

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the finishing state");

  a_search_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_CMP) |-> (lo_q < hi_q))
    else $error("search compare with an empty interval");

  a_rom_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_q <= IDX_W'(ROM_N - 1))
    else $error("table address beyond the last entry");

endmodule
